/* hw/rtl/cc3p_pkg.sv */
package cc3p_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed field widths on the stream ports
    localparam int IN_FIELD_W = 16;
    localparam int IN_FIELDS  = 6;
    localparam int S_DATA_W   = IN_FIELD_W * IN_FIELDS;
    localparam int CENTER_W   = 64;
    localparam int RADIUS_W   = 63;
    localparam int M_DATA_W   = 192;
    localparam int M_USER_W   = 2;

    localparam logic [CENTER_W-1:0] CENTER_MAX = {1'b0, {(CENTER_W-1){1'b1}}};
    localparam logic [CENTER_W-1:0] CENTER_MIN = {1'b1, {(CENTER_W-1){1'b0}}};

    // partial product slice and pipeline depth of the wide multiplier
    localparam int MUL_CHUNK = 24;
    localparam int MUL_LAT   = 3;

endpackage

/* hw/rtl/cc3p_delay.sv */
module cc3p_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                pipe_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[N-1];

endmodule

/* hw/rtl/cc3p_mul.sv */
module cc3p_mul
    import cc3p_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic            clk,
    input  logic            en,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic [AW+BW-1:0] p
);

    localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PW = (NA + NB) * MUL_CHUNK;

    logic [NA*MUL_CHUNK-1:0] a_ext;
    logic [NB*MUL_CHUNK-1:0] b_ext;
    logic [2*MUL_CHUNK-1:0]  pp_reg [NA][NB];
    logic [PW-1:0]           row_reg [NA];
    logic [PW-1:0]           row_next [NA];
    logic [PW-1:0]           sum_next;
    logic [PW-1:0]           sum_reg;

    assign a_ext = (NA*MUL_CHUNK)'(a);
    assign b_ext = (NB*MUL_CHUNK)'(b);

    // slice products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_ext[i*MUL_CHUNK +: MUL_CHUNK]
                                  * b_ext[j*MUL_CHUNK +: MUL_CHUNK];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) << (j*MUL_CHUNK));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                row_reg[i] <= row_next[i];
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            sum_next = sum_next + (row_reg[i] << (i*MUL_CHUNK));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign p = sum_reg[AW+BW-1:0];

endmodule

/* hw/rtl/cc3p_div.sv */
module cc3p_div #(
    parameter int NW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] dvs,
    output logic [NW-1:0] quo
);

    // restoring division, one quotient bit per stage, msb first
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] dvs_reg [NW];

    for (genvar g = 0; g < NW; g++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] quo_in;
        logic [DW-1:0] dvs_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        if (g == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign quo_in = '0;
            assign dvs_in = dvs;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[g-1];
            assign num_in = num_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign dvs_in = dvs_reg[g-1];
        end

        assign trial = {rem_in, num_in[NW-1]};
        assign diff  = trial - {1'b0, dvs_in};
        assign take  = trial >= {1'b0, dvs_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= take ? diff[DW-1:0] : trial[DW-1:0];
                num_reg[g] <= num_in << 1;
                quo_reg[g] <= {quo_in[NW-2:0], take};
                dvs_reg[g] <= dvs_in;
            end
        end
    end

    assign quo = quo_reg[NW-1];

endmodule

/* hw/rtl/cc3p_sqrt.sv */
module cc3p_sqrt #(
    parameter int RW = 8
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] rad,
    output logic [RW-1:0]   root
);

    // digit-by-digit root, one result bit per stage
    logic [RW+1:0]   rem_reg  [RW];
    logic [2*RW-1:0] x_reg    [RW];
    logic [RW-1:0]   root_reg [RW];

    for (genvar g = 0; g < RW; g++)
    begin : g_stage
        logic [RW+1:0]   rem_in;
        logic [2*RW-1:0] x_in;
        logic [RW-1:0]   root_in;
        logic [RW+3:0]   t;
        logic [RW+3:0]   trial;
        logic [RW+3:0]   diff;
        logic            take;

        if (g == 0)
        begin : g_first
            assign rem_in  = '0;
            assign x_in    = rad;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[g-1];
            assign x_in    = x_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        assign t     = {rem_in, x_in[2*RW-1:2*RW-2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign diff  = t - trial;
        assign take  = t >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= take ? diff[RW+1:0] : t[RW+1:0];
                x_reg[g]    <= x_in << 2;
                root_reg[g] <= {root_in[RW-2:0], take};
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

/* hw/rtl/cc3p_front.sv */
module cc3p_front
    import cc3p_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int F  = FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic [S_DATA_W-1:0]       in_data,
    output logic                      vld,
    output logic [3*CW+F+3:0]         dvd_x,
    output logic [3*CW+F+3:0]         dvd_y,
    output logic [2*CW+2:0]           dvs,
    output logic [3*CW+1:0]           nx_mag,
    output logic [3*CW+1:0]           ny_mag,
    output logic [2*CW+1:0]           den_mag,
    output logic                      neg_x,
    output logic                      neg_y,
    output logic signed [CW-1:0]      x1,
    output logic signed [CW-1:0]      y1,
    output logic                      degen
);

    localparam int XW  = (CW > IN_FIELD_W) ? CW : IN_FIELD_W;
    localparam int NSW = 3*CW + 3;
    localparam int NMW = 3*CW + 2;
    localparam int QNW = NMW + F + 2;
    localparam int LAT = 7;

    logic [LAT-1:0] vld_reg;

    logic signed [CW-1:0] crd [IN_FIELDS];

    for (genvar k = 0; k < IN_FIELDS; k++)
    begin : g_crd
        logic [XW-1:0] fext;
        assign fext   = XW'(in_data[k*IN_FIELD_W +: IN_FIELD_W]);
        assign crd[k] = signed'(fext[CW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_vld};
        end
    end

    // A: offsets from the first point
    logic signed [CW-1:0] a_x1_reg, a_y1_reg;
    logic signed [CW:0]   a_bx_reg, a_by_reg, a_cx_reg, a_cy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x1_reg <= crd[0];
            a_y1_reg <= crd[1];
            a_bx_reg <= {crd[2][CW-1], crd[2]} - {crd[0][CW-1], crd[0]};
            a_by_reg <= {crd[3][CW-1], crd[3]} - {crd[1][CW-1], crd[1]};
            a_cx_reg <= {crd[4][CW-1], crd[4]} - {crd[0][CW-1], crd[0]};
            a_cy_reg <= {crd[5][CW-1], crd[5]} - {crd[1][CW-1], crd[1]};
        end
    end

    // B: squares and cross products
    logic signed [CW-1:0]   b_x1_reg, b_y1_reg;
    logic signed [CW:0]     b_bx_reg, b_by_reg, b_cx_reg, b_cy_reg;
    logic signed [2*CW+1:0] b_bxx_reg, b_byy_reg, b_cxx_reg, b_cyy_reg, b_p1_reg, b_p2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_x1_reg  <= a_x1_reg;
            b_y1_reg  <= a_y1_reg;
            b_bx_reg  <= a_bx_reg;
            b_by_reg  <= a_by_reg;
            b_cx_reg  <= a_cx_reg;
            b_cy_reg  <= a_cy_reg;
            b_bxx_reg <= a_bx_reg * a_bx_reg;
            b_byy_reg <= a_by_reg * a_by_reg;
            b_cxx_reg <= a_cx_reg * a_cx_reg;
            b_cyy_reg <= a_cy_reg * a_cy_reg;
            b_p1_reg  <= a_bx_reg * a_cy_reg;
            b_p2_reg  <= a_by_reg * a_cx_reg;
        end
    end

    // C: squared lengths and determinant
    logic signed [CW-1:0]   c_x1_reg, c_y1_reg;
    logic signed [CW:0]     c_bx_reg, c_by_reg, c_cx_reg, c_cy_reg;
    logic [2*CW:0]          c_bsq_reg, c_csq_reg;
    logic signed [2*CW+1:0] c_det_reg;
    logic signed [2*CW+1:0] bsq_next, csq_next;

    assign bsq_next = b_bxx_reg + b_byy_reg;
    assign csq_next = b_cxx_reg + b_cyy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_x1_reg  <= b_x1_reg;
            c_y1_reg  <= b_y1_reg;
            c_bx_reg  <= b_bx_reg;
            c_by_reg  <= b_by_reg;
            c_cx_reg  <= b_cx_reg;
            c_cy_reg  <= b_cy_reg;
            c_bsq_reg <= bsq_next[2*CW:0];
            c_csq_reg <= csq_next[2*CW:0];
            c_det_reg <= b_p1_reg - b_p2_reg;
        end
    end

    // D: numerator products
    logic signed [CW-1:0]   d_x1_reg, d_y1_reg;
    logic signed [2*CW+1:0] d_det_reg;
    logic signed [NSW-1:0]  d_m1_reg, d_m2_reg, d_m3_reg, d_m4_reg;
    logic signed [2*CW+1:0] bsq_s, csq_s;

    assign bsq_s = signed'({1'b0, c_bsq_reg});
    assign csq_s = signed'({1'b0, c_csq_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_x1_reg  <= c_x1_reg;
            d_y1_reg  <= c_y1_reg;
            d_det_reg <= c_det_reg;
            d_m1_reg  <= c_cy_reg * bsq_s;
            d_m2_reg  <= c_by_reg * csq_s;
            d_m3_reg  <= c_bx_reg * csq_s;
            d_m4_reg  <= c_cx_reg * bsq_s;
        end
    end

    // E: numerators, determinant magnitude
    logic signed [CW-1:0]  e_x1_reg, e_y1_reg;
    logic signed [NSW-1:0] e_nx_reg, e_ny_reg;
    logic [2*CW:0]         e_detmag_reg;
    logic                  e_detneg_reg, e_degen_reg;
    logic [2*CW+1:0]       detabs;

    assign detabs = d_det_reg[2*CW+1] ? 0 - d_det_reg : d_det_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_x1_reg     <= d_x1_reg;
            e_y1_reg     <= d_y1_reg;
            e_nx_reg     <= d_m1_reg - d_m2_reg;
            e_ny_reg     <= d_m3_reg - d_m4_reg;
            e_detmag_reg <= detabs[2*CW:0];
            e_detneg_reg <= d_det_reg[2*CW+1];
            e_degen_reg  <= d_det_reg == '0;
        end
    end

    // F: magnitudes and quotient signs
    logic signed [CW-1:0] f_x1_reg, f_y1_reg;
    logic [NMW-1:0]       f_nxm_reg, f_nym_reg;
    logic [2*CW+1:0]      f_den_reg;
    logic                 f_negx_reg, f_negy_reg, f_degen_reg;
    logic [NSW-1:0]       nxabs, nyabs;

    assign nxabs = e_nx_reg[NSW-1] ? 0 - e_nx_reg : e_nx_reg;
    assign nyabs = e_ny_reg[NSW-1] ? 0 - e_ny_reg : e_ny_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_x1_reg    <= e_x1_reg;
            f_y1_reg    <= e_y1_reg;
            f_nxm_reg   <= nxabs[NMW-1:0];
            f_nym_reg   <= nyabs[NMW-1:0];
            f_den_reg   <= {e_detmag_reg, 1'b0};
            f_negx_reg  <= e_nx_reg[NSW-1] ^ e_detneg_reg;
            f_negy_reg  <= e_ny_reg[NSW-1] ^ e_detneg_reg;
            f_degen_reg <= e_degen_reg;
        end
    end

    // G: rounding dividends, round half away from zero
    logic signed [CW-1:0] g_x1_reg, g_y1_reg;
    logic [QNW-1:0]       g_dvdx_reg, g_dvdy_reg;
    logic [2*CW+2:0]      g_dvs_reg;
    logic [NMW-1:0]       g_nxm_reg, g_nym_reg;
    logic [2*CW+1:0]      g_den_reg;
    logic                 g_negx_reg, g_negy_reg, g_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_x1_reg    <= f_x1_reg;
            g_y1_reg    <= f_y1_reg;
            g_dvdx_reg  <= (QNW'(f_nxm_reg) << (F+1)) + QNW'(f_den_reg);
            g_dvdy_reg  <= (QNW'(f_nym_reg) << (F+1)) + QNW'(f_den_reg);
            g_dvs_reg   <= {f_den_reg, 1'b0};
            g_nxm_reg   <= f_nxm_reg;
            g_nym_reg   <= f_nym_reg;
            g_den_reg   <= f_den_reg;
            g_negx_reg  <= f_negx_reg;
            g_negy_reg  <= f_negy_reg;
            g_degen_reg <= f_degen_reg;
        end
    end

    assign vld     = vld_reg[LAT-1];
    assign dvd_x   = g_dvdx_reg;
    assign dvd_y   = g_dvdy_reg;
    assign dvs     = g_dvs_reg;
    assign nx_mag  = g_nxm_reg;
    assign ny_mag  = g_nym_reg;
    assign den_mag = g_den_reg;
    assign neg_x   = g_negx_reg;
    assign neg_y   = g_negy_reg;
    assign x1      = g_x1_reg;
    assign y1      = g_y1_reg;
    assign degen   = g_degen_reg;

endmodule

/* hw/rtl/circumcircle_from_three_points_top.sv */
// Circumcircle of three points, fully pipelined.
// Pipeline length from input to output transfer is set by the bit-per-stage square root
// and radius divider.
// Throughput: one item per cycle; a stall on the output freezes the whole pipeline.
// Reset: asynchronous, active low; clears all valid bits and the delay lines, other
// data registers are not reset.
module circumcircle_from_three_points_top
    import cc3p_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y (16 bits each)
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // centre x (64), centre y (64), radius (63), zero pad (1)
    output logic [M_DATA_W-1:0] m_tdata,
    // degenerate, saturated
    output logic [M_USER_W-1:0] m_tuser
);

    localparam int CW   = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int NMW  = 3*CW + 2;
    localparam int QNW  = NMW + F + 2;
    localparam int DMW  = 2*CW + 2;
    localparam int RW   = NMW + F + 1;
    localparam int SQW  = 2*NMW + 1;
    localparam int RLAT = MUL_LAT + 1 + 2*RW;
    localparam int CDLY = RLAT - QNW - 1;
    localparam int EW0  = ((QNW > CW + F) ? QNW : CW + F) + 2;
    localparam int EW   = (EW0 > CENTER_W + 1) ? EW0 : CENTER_W + 1;
    localparam int RXW  = (RW > CENTER_W) ? RW : CENTER_W;

    logic en;

    logic                 f_vld;
    logic [QNW-1:0]       f_dvdx, f_dvdy;
    logic [DMW:0]         f_dvs;
    logic [NMW-1:0]       f_nxm, f_nym;
    logic [DMW-1:0]       f_den;
    logic                 f_negx, f_negy, f_degen;
    logic signed [CW-1:0] f_x1, f_y1;

    logic                m_tvalid_reg;
    logic [CENTER_W-1:0] ctr_x_reg, ctr_y_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic                degenerate_reg, saturated_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    cc3p_front #(.CW(CW), .F(F)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_tvalid),
        .in_data (s_tdata),
        .vld     (f_vld),
        .dvd_x   (f_dvdx),
        .dvd_y   (f_dvdy),
        .dvs     (f_dvs),
        .nx_mag  (f_nxm),
        .ny_mag  (f_nym),
        .den_mag (f_den),
        .neg_x   (f_negx),
        .neg_y   (f_negy),
        .x1      (f_x1),
        .y1      (f_y1),
        .degen   (f_degen)
    );

    // ---- centre path ----
    logic [QNW-1:0]       qx, qy;
    logic                 d_negx, d_negy;
    logic signed [CW-1:0] d_x1, d_y1;

    cc3p_div #(.NW(QNW), .DW(DMW+1)) u_div_x (
        .clk (clk), .en (en), .num (f_dvdx), .dvs (f_dvs), .quo (qx)
    );

    cc3p_div #(.NW(QNW), .DW(DMW+1)) u_div_y (
        .clk (clk), .en (en), .num (f_dvdy), .dvs (f_dvs), .quo (qy)
    );

    cc3p_delay #(.W(2*CW+2), .N(QNW)) u_dly_side (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   ({f_negx, f_negy, f_x1, f_y1}),
        .dout  ({d_negx, d_negy, d_x1, d_y1})
    );

    logic signed [EW-1:0] totx, toty;
    logic                 fitx, fity;
    logic [CENTER_W-1:0]  cx_reg, cy_reg;
    logic                 csat_reg;

    assign totx = (EW'(d_x1) <<< F) + (d_negx ? 0 - EW'(qx) : EW'(qx));
    assign toty = (EW'(d_y1) <<< F) + (d_negy ? 0 - EW'(qy) : EW'(qy));
    // fits when all bits from 63 up agree with the sign
    assign fitx = (&totx[EW-1:CENTER_W-1]) || !(|totx[EW-1:CENTER_W-1]);
    assign fity = (&toty[EW-1:CENTER_W-1]) || !(|toty[EW-1:CENTER_W-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg   <= fitx ? totx[CENTER_W-1:0] : (totx[EW-1] ? CENTER_MIN : CENTER_MAX);
            cy_reg   <= fity ? toty[CENTER_W-1:0] : (toty[EW-1] ? CENTER_MIN : CENTER_MAX);
            csat_reg <= !fitx || !fity;
        end
    end

    logic [CENTER_W-1:0] al_cx, al_cy;
    logic                al_csat;

    cc3p_delay #(.W(2*CENTER_W+1), .N(CDLY)) u_dly_center (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   ({cx_reg, cy_reg, csat_reg}),
        .dout  ({al_cx, al_cy, al_csat})
    );

    // ---- radius path: floor(isqrt((nx^2 + ny^2) << 2F) / |den|) ----
    logic [2*NMW-1:0] nxsq, nysq;
    logic [SQW-1:0]   sq_reg;
    logic [RW-1:0]    root;
    logic [DMW-1:0]   den_al;
    logic [RW-1:0]    rq;

    cc3p_mul #(.AW(NMW), .BW(NMW)) u_mul_x (
        .clk (clk), .en (en), .a (f_nxm), .b (f_nxm), .p (nxsq)
    );

    cc3p_mul #(.AW(NMW), .BW(NMW)) u_mul_y (
        .clk (clk), .en (en), .a (f_nym), .b (f_nym), .p (nysq)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= SQW'(nxsq) + SQW'(nysq);
        end
    end

    cc3p_sqrt #(.RW(RW)) u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  ((2*RW)'(sq_reg) << (2*F)),
        .root (root)
    );

    cc3p_delay #(.W(DMW), .N(MUL_LAT+1+RW)) u_dly_den (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (f_den),
        .dout  (den_al)
    );

    cc3p_div #(.NW(RW), .DW(DMW)) u_div_r (
        .clk (clk), .en (en), .num (root), .dvs (den_al), .quo (rq)
    );

    logic [RXW-1:0] rq_ext;
    logic           rsat;

    assign rq_ext = RXW'(rq);
    assign rsat   = |rq_ext[RXW-1:RADIUS_W];

    // valid and degenerate flag ride alongside the whole path
    logic al_vld, al_degen;

    cc3p_delay #(.W(2), .N(RLAT)) u_dly_vld (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   ({f_vld, f_degen}),
        .dout  ({al_vld, al_degen})
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= al_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctr_x_reg      <= al_degen ? '0 : al_cx;
            ctr_y_reg      <= al_degen ? '0 : al_cy;
            radius_reg     <= al_degen ? '0 : (rsat ? '1 : rq_ext[RADIUS_W-1:0]);
            saturated_reg  <= !al_degen && (al_csat || rsat);
            degenerate_reg <= al_degen;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, radius_reg, ctr_y_reg, ctr_x_reg};
    assign m_tuser  = {saturated_reg, degenerate_reg};

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import cc3p_pkg::*;

    typedef struct packed {
        logic [63:0] cx;
        logic [63:0] cy;
        logic [62:0] rad;
        logic        degen;
        logic        sat;
    } circle_t;

    typedef struct {
        logic [S_DATA_W-1:0] pts;
        bit                  has_exp;
        circle_t             exp;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    circle_t   circle_q[$];
    stim_row_t rows[$];
    int        mismatches;
    int        sent;

    circumcircle_from_three_points_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic signed [255:0] sx16(input logic [15:0] v);
        return {{240{v[15]}}, v};
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_pts(input int fx, fy, sx, sy, tx, ty);
        logic [15:0] a, b, c, d, e, f;
        a = fx[15:0]; b = fy[15:0]; c = sx[15:0];
        d = sy[15:0]; e = tx[15:0]; f = ty[15:0];
        return {f, e, d, c, b, a};
    endfunction

    // rounded offset added to base, clamped to 64 bits; top bit of result is the clamp flag
    function automatic logic [64:0] place_center(input logic signed [255:0] base, num, den);
        logic [255:0]        nm, dm, off;
        logic signed [255:0] tot, hi, lo;
        nm  = num < 0 ? -num : num;
        dm  = den < 0 ? -den : den;
        off = ((nm << (FRAC_BITS_DEF + 1)) + dm) / (dm << 1);
        tot = (base <<< FRAC_BITS_DEF) + (((num < 0) != (den < 0)) ? -off : off);
        hi  = 256'h7fff_ffff_ffff_ffff;
        lo  = -hi - 1;
        if (tot > hi)
            return {1'b1, CENTER_MAX};
        if (tot < lo)
            return {1'b1, CENTER_MIN};
        return {1'b0, tot[63:0]};
    endfunction

    function automatic circle_t predict_circle(input logic [S_DATA_W-1:0] pts);
        logic signed [255:0] x1, y1, bx, by, cx, cy, bsq, csq, det, den, nx, ny;
        logic [255:0]        s, d2, q, r, cand, dm, mx, my;
        logic [64:0]         px, py;
        circle_t             o;
        o  = '0;
        x1 = sx16(pts[15:0]);
        y1 = sx16(pts[31:16]);
        bx = sx16(pts[47:32]) - x1;
        by = sx16(pts[63:48]) - y1;
        cx = sx16(pts[79:64]) - x1;
        cy = sx16(pts[95:80]) - y1;
        bsq = bx * bx + by * by;
        csq = cx * cx + cy * cy;
        det = bx * cy - by * cx;
        if (det == 0)
        begin
            o.degen = 1'b1;
            return o;
        end
        den = det <<< 1;
        nx  = cy * bsq - by * csq;
        ny  = bx * csq - cx * bsq;
        px  = place_center(x1, nx, den);
        py  = place_center(y1, ny, den);
        o.cx = px[63:0];
        o.cy = py[63:0];
        o.sat = px[64] | py[64];
        mx = nx < 0 ? -nx : nx;
        my = ny < 0 ? -ny : ny;
        dm = den < 0 ? -den : den;
        s  = (mx * mx + my * my) << (2 * FRAC_BITS_DEF);
        d2 = dm * dm;
        q  = s / d2;
        r  = '0;
        for (int i = 127; i >= 0; i--)
        begin
            cand = r | (256'd1 << i);
            if (cand * cand <= q)
                r = cand;
        end
        if (r > 256'h7fff_ffff_ffff_ffff)
        begin
            o.rad = {63{1'b1}};
            o.sat = 1'b1;
        end
        else
            o.rad = r[62:0];
        return o;
    endfunction

    function automatic void add_row(input logic [S_DATA_W-1:0] pts, input bit degen_only);
        stim_row_t row;
        row.pts     = pts;
        row.has_exp = degen_only;
        row.exp     = '0;
        row.exp.degen = degen_only;
        rows.push_back(row);
    endfunction

    // output check
    always @(posedge clk)
    begin
        circle_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.cx    = m_tdata[63:0];
            got.cy    = m_tdata[127:64];
            got.rad   = m_tdata[190:128];
            got.degen = m_tuser[0];
            got.sat   = m_tuser[1];
            if (circle_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %p", got);
            end
            else
            begin
                want = circle_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %b %b got %h %h %h %b %b",
                                 want.cx, want.cy, want.rad, want.degen, want.sat,
                                 got.cx, got.cy, got.rad, got.degen, got.sat);
                end
            end
        end
    end

    // receiver: alternating stall patterns, plus one long hold-off
    initial
    begin
        int  cyc;
        bit  held;
        m_tready = 1'b0;
        held     = 1'b0;
        cyc      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (!held && sent >= 300)
            begin
                held     = 1'b1;
                m_tready = 1'b0;
                repeat (500) @(negedge clk);
            end
            case ((cyc / 200) % 4)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 3) != 0);
                2: m_tready = ((cyc % 7) < 3);
                default: m_tready = 1'($urandom_range(0, 1));
            endcase
        end
    end

    // stimulus
    initial
    begin
        int        burst;
        int        a, b, c, d, e, f, k;
        stim_row_t row;
        circle_t   want;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        mismatches = 0;
        sent      = 0;
        burst     = 0;

        add_row(pack_pts(0, 0, 0, 0, 0, 0), 1'b1);
        add_row(pack_pts(-32768, -32768, -32768, -32768, -32768, -32768), 1'b1);
        add_row(pack_pts(32767, 32767, 32767, 32767, 32767, 32767), 1'b1);
        add_row(pack_pts(-32768, -32768, 0, 0, 32767, 32767), 1'b1);
        add_row(pack_pts(5, 7, 5, 7, -3, 100), 1'b1);
        add_row(pack_pts(10, -4, 10, 20, 10, 32767), 1'b1);
        add_row(pack_pts(0, 0, 2, 0, 0, 2), 1'b0);
        add_row(pack_pts(0, 0, 1, 0, 0, 1), 1'b0);
        add_row(pack_pts(-32768, -32768, 32767, -32768, -32768, 32767), 1'b0);
        add_row(pack_pts(32767, 32767, -32768, 32767, 32767, -32768), 1'b0);
        add_row(pack_pts(-32768, 32767, 32767, 32767, 0, -32768), 1'b0);
        add_row(pack_pts(-32768, -32768, 32767, 32766, 32766, 32765), 1'b0);
        add_row(pack_pts(32767, 32767, -32768, -32767, -32767, -32766), 1'b0);
        add_row(pack_pts(0, 0, 32767, 1, -32768, 0), 1'b0);
        add_row(pack_pts(-1, -1, 1, -1, -1, 1), 1'b0);
        add_row(pack_pts(3, 4, -3, 4, 3, -4), 1'b0);
        add_row(pack_pts(0, 0, 1, 1, 2, 1), 1'b0);

        for (int i = 0; i < 690; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 5)
            begin
                a = $urandom; b = $urandom; c = $urandom;
                d = $urandom; e = $urandom; f = $urandom;
            end
            else if (k < 8)
            begin
                a = $urandom_range(0, 40) - 20; b = $urandom_range(0, 40) - 20;
                c = $urandom_range(0, 40) - 20; d = $urandom_range(0, 40) - 20;
                e = $urandom_range(0, 40) - 20; f = $urandom_range(0, 40) - 20;
            end
            else
            begin
                // nearly collinear, wide spread: large centres, may clamp
                a = $urandom_range(0, 65535) - 32768;
                b = $urandom_range(0, 65535) - 32768;
                c = $urandom_range(0, 65535) - 32768;
                d = $urandom_range(0, 65535) - 32768;
                e = (a + c) / 2 + int'($urandom_range(0, 2)) - 1;
                f = (b + d) / 2 + int'($urandom_range(0, 2)) - 1;
            end
            add_row(pack_pts(a, b, c, d, e, f), 1'b0);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            if (burst == 0)
            begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
                burst = $urandom_range(1, 40);
            end
            want = row.has_exp ? row.exp : predict_circle(row.pts);
            s_tvalid = 1'b1;
            s_tdata  = row.pts;
            do
                @(posedge clk);
            while (!s_tready);
            circle_q.push_back(want);
            sent++;
            @(negedge clk);
            burst--;
        end
        s_tvalid  = 1'b0;

        while (circle_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* circumcircle_from_three_points_top.f */
hw/rtl/cc3p_pkg.sv
hw/rtl/cc3p_delay.sv
hw/rtl/cc3p_mul.sv
hw/rtl/cc3p_div.sv
hw/rtl/cc3p_sqrt.sv
hw/rtl/cc3p_front.sv
hw/rtl/circumcircle_from_three_points_top.sv
tb/sv/tb_top.sv
